FILE: rtl/lzwd_pkg.sv
package lzwd_pkg;

  localparam int MAX_CODE_WIDTH_DEF   = 12;
  localparam int MAX_STRING_BYTES_DEF = 512;
  localparam int CODE_W               = 12;
  localparam int CFG_W                = 4;
  localparam int WIDTH_W              = 5;
  localparam int MIN_WIDTH            = 9;
  localparam int START_WIDTH_RST      = 9;
  localparam int LITERAL_CODES        = 256;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CODE = 2'd1,
    ERR_FULL = 2'd2,
    ERR_LONG = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0,
    CLS_NONE  = 2'd1,
    CLS_WALK  = 2'd2
  } cls_t;

  typedef struct packed {
    logic accept;
    logic classify;
    logic walk;
    logic wait_rd;
    logic finish;
    logic emit_wr;
    logic push;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic walk_over;
    logic walk_root;
    logic wr_flush;
    logic more;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/lzwd_ctrl.sv
module lzwd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lzwd_pkg::sts_t sts,
  output lzwd_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_FIN   = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_WR    = 8'b0100_0000,
    S_PUSH  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        if (sts.cls == lzwd_pkg::CLS_NONE) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_over) begin
          state_next = S_PUSH;
        end else if (sts.walk_root) begin
          state_next = S_FIN;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.wait_rd = 1'b1;
        state_next = S_WALK;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        state_next = S_WR;
      end
      S_WR: begin
        cmd.emit_wr = 1'b1;
        state_next = sts.wr_flush ? S_PUSH : S_RD;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          state_next = sts.more ? S_RD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

FILE: rtl/lzwd_dp.sv
module lzwd_dp #(
  parameter int MAX_CODE_WIDTH   = lzwd_pkg::MAX_CODE_WIDTH_DEF,
  parameter int MAX_STRING_BYTES = lzwd_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lzwd_pkg::CODE_W-1:0] code_value,
  input  logic                        start_code_width_we,
  input  logic [lzwd_pkg::CFG_W-1:0]  start_code_width,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [63:0]                 out_bytes,
  output logic [3:0]                  byte_count,
  output logic                        last_of_run,
  output logic [3:0]                  width_now,
  output logic [1:0]                  error_kind,
  input  lzwd_pkg::cmd_t              cmd,
  output lzwd_pkg::sts_t              sts
);

  localparam int CW    = MAX_CODE_WIDTH;
  localparam int DEPTH = 1 << CW;
  localparam int DW    = CW + 8;
  localparam int SW    = $clog2(MAX_STRING_BYTES);
  localparam int LW    = SW + 1;
  localparam int CMPW  = (CW + 1 > lzwd_pkg::CODE_W) ? CW + 1 : lzwd_pkg::CODE_W;
  localparam int WW    = lzwd_pkg::WIDTH_W;

  logic [DW-1:0] dict [DEPTH];
  logic [DW-1:0] dict_rdata;
  logic [7:0]    stk [MAX_STRING_BYTES];
  logic [7:0]    stk_rdata;

  logic [lzwd_pkg::CODE_W-1:0] code_q;
  logic [WW-1:0]  cw;
  logic           seen_first;
  logic [CW-1:0]  prev;
  logic [7:0]     first_byte;
  logic [CW:0]    next_free;
  lzwd_pkg::err_t err;
  logic [CW-1:0]  c;
  logic [LW-1:0]  len;
  logic [LW-1:0]  limit;
  logic           kw;
  logic           first_mode;
  logic [LW-1:0]  stk_left;
  logic           kw_left;
  logic [63:0]    word;
  logic [3:0]     slot;

  logic [CMPW-1:0] code_x, nf_x, esc_x, depth_x;
  logic            is_esc, is_bad, is_kw, first_bad, full, c_root, more_after;
  logic [WW-1:0]   cfg_w, cfg_clamped;
  logic [7:0]      emit_byte;

  assign code_x   = CMPW'(code_q);
  assign nf_x     = CMPW'(next_free);
  assign depth_x  = CMPW'(DEPTH);
  assign esc_x    = (CMPW'(1) << cw) - CMPW'(1);
  assign is_esc   = (code_x == esc_x);
  assign is_bad   = (code_x >= depth_x) || (code_x > nf_x);
  assign is_kw    = (code_x == nf_x);
  assign first_bad = (code_q[lzwd_pkg::CODE_W-1:8] != '0);
  assign full     = (next_free == (CW+1)'(DEPTH));
  assign c_root   = (c[CW-1:8] == '0);
  assign more_after = (stk_left != '0) && ((stk_left > LW'(1)) || kw_left);
  assign emit_byte  = (stk_left != '0) ? stk_rdata : first_byte;

  assign cfg_w = WW'(start_code_width);
  always_comb begin
    if (cfg_w < WW'(lzwd_pkg::MIN_WIDTH)) begin
      cfg_clamped = WW'(lzwd_pkg::MIN_WIDTH);
    end else if (cfg_w > WW'(MAX_CODE_WIDTH)) begin
      cfg_clamped = WW'(MAX_CODE_WIDTH);
    end else begin
      cfg_clamped = cfg_w;
    end
  end

  always_comb begin
    if (!seen_first) begin
      sts.cls = first_bad ? lzwd_pkg::CLS_NONE : lzwd_pkg::CLS_FIRST;
    end else if (is_esc || is_bad) begin
      sts.cls = lzwd_pkg::CLS_NONE;
    end else begin
      sts.cls = lzwd_pkg::CLS_WALK;
    end
    sts.walk_over = (len >= limit);
    sts.walk_root = c_root;
    sts.wr_flush  = (slot == 4'd7) || !more_after;
    sts.more      = (stk_left != '0) || kw_left;
    sts.out_free  = !out_valid || !out_stall;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.finish && !first_mode && !full) begin
      dict[next_free[CW-1:0]] <= {prev, c[7:0]};
    end
    dict_rdata <= dict[c];
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && !sts.walk_over && c_root) begin
      stk[len[SW-1:0]] <= c[7:0];
    end else if (cmd.wait_rd) begin
      stk[len[SW-1:0]] <= dict_rdata[7:0];
    end
    stk_rdata <= stk[SW'(stk_left - LW'(1))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cw         <= WW'(lzwd_pkg::START_WIDTH_RST);
      seen_first <= 1'b0;
      prev       <= '0;
      first_byte <= '0;
      next_free  <= (CW+1)'(lzwd_pkg::LITERAL_CODES);
      out_valid  <= 1'b0;
      stk_left   <= '0;
      kw_left    <= 1'b0;
    end else begin
      if (start_code_width_we) begin
        if (!seen_first) begin
          cw <= cfg_clamped;
        end
      end

      if (cmd.accept) begin
        code_q <= code_value;
      end

      if (cmd.classify) begin
        word       <= '0;
        slot       <= '0;
        stk_left   <= '0;
        kw_left    <= 1'b0;
        len        <= '0;
        kw         <= 1'b0;
        limit      <= LW'(MAX_STRING_BYTES);
        first_mode <= !seen_first;
        err        <= lzwd_pkg::ERR_NONE;
        c          <= CW'(code_q);
        if (!seen_first) begin
          if (first_bad) begin
            err <= lzwd_pkg::ERR_CODE;
          end
        end else if (is_esc) begin
          if (cw >= WW'(MAX_CODE_WIDTH)) begin
            err <= lzwd_pkg::ERR_FULL;
          end else begin
            cw <= cw + WW'(1);
          end
        end else if (is_bad) begin
          err <= lzwd_pkg::ERR_CODE;
        end else begin
          kw    <= is_kw;
          c     <= is_kw ? prev : CW'(code_q);
          limit <= LW'(MAX_STRING_BYTES) - LW'(is_kw);
        end
      end

      if (cmd.walk) begin
        if (sts.walk_over) begin
          err <= lzwd_pkg::ERR_LONG;
        end else if (c_root) begin
          len <= len + LW'(1);
        end
      end

      if (cmd.wait_rd) begin
        len <= len + LW'(1);
        c   <= dict_rdata[DW-1:8];
      end

      if (cmd.finish) begin
        stk_left   <= len;
        kw_left    <= kw;
        first_byte <= c[7:0];
        prev       <= CW'(code_q);
        if (first_mode) begin
          seen_first <= 1'b1;
        end else if (full) begin
          err <= lzwd_pkg::ERR_FULL;
        end else begin
          next_free <= next_free + (CW+1)'(1);
        end
      end

      if (cmd.emit_wr) begin
        word[slot[2:0]*8 +: 8] <= emit_byte;
        slot <= slot + 4'd1;
        if (stk_left != '0) begin
          stk_left <= stk_left - LW'(1);
        end else begin
          kw_left <= 1'b0;
        end
      end

      if (cmd.push) begin
        out_valid   <= 1'b1;
        out_bytes   <= word;
        byte_count  <= slot;
        last_of_run <= !sts.more;
        width_now   <= cw[3:0];
        error_kind  <= err;
        word        <= '0;
        slot        <= '0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/lzw_code_decoder_unit.sv
// Steps: accept and classify a code, walk the prefix chain one byte at a time
//   (registered dictionary read, none for the root byte), finish, then emit the
//   bytes and output each result word; an escape or bad code skips the walk.
// Throughput: one code at a time; in_stall stays high until the code's last
//   result word is pushed, and out_stall holds the output and adds to the wait.
// Reset (rst, synchronous): width back to start value 9, next free code 256,
//   no first code seen; dictionary and stack contents are not cleared.
module lzw_code_decoder_unit #(
  parameter int MAX_CODE_WIDTH   = lzwd_pkg::MAX_CODE_WIDTH_DEF,
  parameter int MAX_STRING_BYTES = lzwd_pkg::MAX_STRING_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lzwd_pkg::CODE_W-1:0] code_value,
  input  logic                        start_code_width_we,
  input  logic [lzwd_pkg::CFG_W-1:0]  start_code_width,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [63:0]                 out_bytes,
  output logic [3:0]                  byte_count,
  output logic                        last_of_run,
  output logic [3:0]                  width_now,
  output logic [1:0]                  error_kind
);

  lzwd_pkg::cmd_t cmd;
  lzwd_pkg::sts_t sts;

  lzwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwd_dp #(
    .MAX_CODE_WIDTH   (MAX_CODE_WIDTH),
    .MAX_STRING_BYTES (MAX_STRING_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .code_value          (code_value),
    .start_code_width_we (start_code_width_we),
    .start_code_width    (start_code_width),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_bytes           (out_bytes),
    .byte_count          (byte_count),
    .last_of_run         (last_of_run),
    .width_now           (width_now),
    .error_kind          (error_kind),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

FILE: rtl/lzwd_chk.sv
module lzwd_chk (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_bytes,
  input logic [3:0]  byte_count,
  input logic        last_of_run,
  input logic [3:0]  width_now,
  input logic [1:0]  error_kind
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_bytes))
    else $error("item changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= 4'd8)
    else $error("byte count above 8");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 4'd0 |-> last_of_run)
    else $error("empty item not last");

  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> width_now >= 4'd9)
    else $error("width below minimum");

  a_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_kind == 2'd3 |-> byte_count == 4'd0 && out_bytes == 64'd0)
    else $error("bytes on too-long error");

endmodule

bind lzw_code_decoder_unit lzwd_chk u_chk (.*);
